>>> sv/ttps_pkg.sv
// Shared types, codes and score helpers for the transposition table block.
package ttps_pkg;

   localparam int unsigned DEFAULT_TABLE_ENTRIES = 65536;

   localparam int unsigned KEY_W   = 64;
   localparam int unsigned PLY_W   = 6;
   localparam int unsigned DEPTH_W = 6;
   localparam int unsigned MOVE_W  = 25;
   localparam int unsigned SCORE_W = 16;
   localparam int unsigned BOUND_W = 2;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned THR_W   = 15;
   localparam int unsigned KIND_W  = 2;

   localparam int unsigned REQ_TDATA_W = 152;
   localparam int unsigned RSP_TDATA_W = 144;
   localparam int unsigned RSP_TUSER_W = 2;

   localparam logic [THR_W-1:0] MATE_THRESHOLD_RESET = 15'd29936;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = 1;

   localparam logic [KIND_W-1:0] REQ_STORE = 2'd0;
   localparam logic [KIND_W-1:0] REQ_PROBE = 2'd1;
   localparam logic [KIND_W-1:0] REQ_CLEAR = 2'd2;

   localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd0;
   localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
   localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]         req_type;
      logic [KEY_W-1:0]          position_key;
      logic [PLY_W-1:0]          search_ply;
      logic [DEPTH_W-1:0]        req_depth;
      logic [MOVE_W-1:0]         entry_move;
      logic signed [SCORE_W-1:0] entry_score;
      logic [BOUND_W-1:0]        bound_kind;
      logic signed [SCORE_W-1:0] window_alpha;
      logic signed [SCORE_W-1:0] window_beta;
   } req_item_type;

   typedef struct packed {
      logic [KEY_W-1:0]          key;
      logic [BOUND_W-1:0]        bound;
      logic [DEPTH_W-1:0]        depth;
      logic signed [SCORE_W-1:0] score;
      logic [MOVE_W-1:0]         move;
   } slot_type;

   typedef struct packed {
      logic                      key_found;
      logic                      cutoff;
      logic [MOVE_W-1:0]         found_move;
      logic signed [SCORE_W-1:0] found_score;
      logic [COUNT_W-1:0]        hit_count;
      logic [COUNT_W-1:0]        new_write_count;
      logic [COUNT_W-1:0]        overwrite_count;
   } result_type;

   // Moves a mate score away from zero by the ply (away = 1) or back toward
   // zero (away = 0), saturating to the signed 16-bit range.
   function automatic logic signed [SCORE_W-1:0] mate_adjust(
      input logic signed [SCORE_W-1:0] score,
      input logic [THR_W-1:0]          thr,
      input logic [PLY_W-1:0]          ply,
      input logic                      away
   );
      logic signed [SCORE_W:0] wide;
      logic signed [SCORE_W:0] lim;
      logic signed [SCORE_W:0] delta;
      logic signed [SCORE_W:0] sum;
      logic signed [SCORE_W-1:0] res;
      wide  = $signed({score[SCORE_W-1], score});
      lim   = $signed({2'b00, thr});
      delta = $signed({{(SCORE_W+1-PLY_W){1'b0}}, ply});
      if (!away) begin
         delta = -delta;
      end
      if (wide > lim) begin
         sum = wide + delta;
      end else if (wide < -lim) begin
         sum = wide - delta;
      end else begin
         sum = wide;
      end
      if (sum > 17'sd32767) begin
         res = 16'sh7FFF;
      end else if (sum < -17'sd32768) begin
         res = 16'sh8000;
      end else begin
         res = sum[SCORE_W-1:0];
      end
      return res;
   endfunction

endpackage

>>> sv/ttps_front.sv
// Front part: accepts items, applies the store mate shift and forms the slot index.
module ttps_front #(
   parameter int unsigned TABLE_ENTRIES = ttps_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   input  ttps_pkg::req_item_type                     req_item,
   input  logic [ttps_pkg::THR_W-1:0]                 mate_threshold,
   input  logic                                       init_busy,
   output logic                                       push_valid,
   input  logic                                       push_ready,
   output ttps_pkg::req_item_type                     push_item,
   output logic [$clog2(TABLE_ENTRIES)-1:0]           push_index
);
   import ttps_pkg::*;

   localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
   localparam bit POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

   req_item_type     item_ff, item_in;
   logic             valid_ff, valid_in;
   logic             idx_done;
   logic [IDX_W-1:0] idx_value;
   logic             accept;

   assign accept     = req_tvalid && req_tready;
   assign push_valid = valid_ff && idx_done;
   assign req_tready = !init_busy && (!valid_ff || (idx_done && push_ready));
   assign push_item  = item_ff;
   assign push_index = idx_value;

   always_comb begin
      item_in  = item_ff;
      valid_in = valid_ff;
      if (push_valid && push_ready) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
         item_in  = req_item;
         if (req_item.req_type == REQ_STORE) begin
            item_in.entry_score = mate_adjust(req_item.entry_score, mate_threshold,
                                              req_item.search_ply, 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   if (POW2) begin : g_pow2
      assign idx_done  = 1'b1;
      assign idx_value = item_ff.position_key[IDX_W-1:0];
   end else begin : g_serial
      // The key is reduced modulo the table size a byte per cycle, most
      // significant byte first, one conditional subtract per key bit.
      localparam logic [IDX_W:0] MODULUS = (IDX_W + 1)'(TABLE_ENTRIES);

      logic [2:0]       step_ff, step_in;
      logic             run_ff, run_in;
      logic [IDX_W-1:0] residue_ff, residue_in;
      logic [7:0][7:0]  key_bytes;
      logic [7:0]       cur_byte;

      assign key_bytes = item_ff.position_key;
      assign cur_byte  = key_bytes[~step_ff];
      assign idx_done  = !run_ff;
      assign idx_value = residue_ff;

      always_comb begin
         logic [IDX_W:0]   t;
         logic [IDX_W-1:0] r;
         r = residue_ff;
         for (int i = 0; i < 8; i++) begin
            t = {r, cur_byte[3'(7 - i)]};
            if (t >= MODULUS) begin
               t = t - MODULUS;
            end
            r = t[IDX_W-1:0];
         end
         step_in    = step_ff;
         run_in     = run_ff;
         residue_in = residue_ff;
         if (run_ff) begin
            residue_in = r;
            step_in    = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               run_in = 1'b0;
            end
         end
         if (accept) begin
            residue_in = '0;
            step_in    = '0;
            run_in     = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            run_ff  <= 1'b0;
            step_ff <= '0;
         end else begin
            run_ff  <= run_in;
            step_ff <= step_in;
         end
         residue_ff <= residue_in;
      end
   end

endmodule

>>> sv/ttps_queue.sv
// Short item queue between the front and back parts.
module ttps_queue #(
   parameter int unsigned IDX_W = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  ttps_pkg::req_item_type push_item,
   input  logic [IDX_W-1:0]       push_index,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output ttps_pkg::req_item_type pop_item,
   output logic [IDX_W-1:0]       pop_index
);
   import ttps_pkg::*;

   req_item_type             items_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0]         index_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;
   logic                     push_fire, pop_fire;

   assign push_ready = count_ff != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_item   = items_ff[rd_ptr_ff];
   assign pop_index  = index_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + (QUEUE_PTR_W + 1)'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - (QUEUE_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_fire) begin
         items_ff[wr_ptr_ff] <= push_item;
         index_ff[wr_ptr_ff] <= push_index;
      end
   end

endmodule

>>> sv/ttps_back.sv
// Back part: slot memory, clearing sweep, store and probe execution, counters and result register.
module ttps_back #(
   parameter int unsigned TABLE_ENTRIES = ttps_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [ttps_pkg::THR_W-1:0]       mate_threshold,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   input  ttps_pkg::req_item_type           pop_item,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] pop_index,
   output logic                             init_busy,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ttps_pkg::result_type             rsp_item
);
   import ttps_pkg::*;

   localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(TABLE_ENTRIES - 1);

   localparam logic [1:0] ST_SWEEP = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_LOOK  = 2'd2;
   localparam logic [1:0] ST_REPLY = 2'd3;

   slot_type mem [TABLE_ENTRIES];

   logic [1:0]                state_ff, state_in;
   logic                      init_ff, init_in;
   logic [IDX_W-1:0]          sweep_addr_ff, sweep_addr_in;
   req_item_type              cur_ff, cur_in;
   logic [IDX_W-1:0]          cur_index_ff, cur_index_in;
   slot_type                  rd_slot_ff;
   logic                      match_ff, match_in;
   logic                      empty_ff, empty_in;
   logic                      deep_ff, deep_in;
   logic signed [SCORE_W-1:0] score_ff, score_in;
   logic [COUNT_W-1:0]        hits_ff, hits_in;
   logic [COUNT_W-1:0]        new_writes_ff, new_writes_in;
   logic [COUNT_W-1:0]        overwrites_ff, overwrites_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   result_type                rsp_ff, rsp_in;

   logic                      mem_we;
   logic [IDX_W-1:0]          mem_addr;
   slot_type                  mem_wdata;
   logic                      pop_fire;
   logic                      out_free;

   assign pop_ready = state_ff == ST_IDLE;
   assign pop_fire  = pop_valid && pop_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign init_busy = init_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      result_type res;
      res           = '0;
      state_in      = state_ff;
      init_in       = init_ff;
      sweep_addr_in = sweep_addr_ff;
      cur_in        = cur_ff;
      cur_index_in  = cur_index_ff;
      match_in      = match_ff;
      empty_in      = empty_ff;
      deep_in       = deep_ff;
      score_in      = score_ff;
      hits_in       = hits_ff;
      new_writes_in = new_writes_ff;
      overwrites_in = overwrites_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mem_we        = 1'b0;
      mem_addr      = sweep_addr_ff;
      mem_wdata     = '0;

      unique case (state_ff)
         ST_SWEEP: begin
            mem_we        = 1'b1;
            sweep_addr_in = sweep_addr_ff + IDX_W'(1);
            if (sweep_addr_ff == LAST_INDEX) begin
               sweep_addr_in = '0;
               if (init_ff) begin
                  init_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end
         ST_IDLE: begin
            if (pop_valid) begin
               cur_in       = pop_item;
               cur_index_in = pop_index;
               unique case (pop_item.req_type)
                  REQ_STORE, REQ_PROBE: state_in = ST_LOOK;
                  REQ_CLEAR:            state_in = ST_SWEEP;
                  default:              state_in = ST_REPLY;
               endcase
            end
         end
         ST_LOOK: begin
            match_in = rd_slot_ff.key == cur_ff.position_key;
            empty_in = rd_slot_ff.key == '0;
            deep_in  = rd_slot_ff.depth >= cur_ff.req_depth;
            score_in = mate_adjust(rd_slot_ff.score, mate_threshold,
                                   cur_ff.search_ply, 1'b0);
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (out_free) begin
               case (cur_ff.req_type)
                  REQ_STORE: begin
                     if (empty_ff) begin
                        new_writes_in = new_writes_ff + COUNT_W'(1);
                     end else begin
                        overwrites_in = overwrites_ff + COUNT_W'(1);
                     end
                     mem_we          = 1'b1;
                     mem_addr        = cur_index_ff;
                     mem_wdata.key   = cur_ff.position_key;
                     mem_wdata.bound = cur_ff.bound_kind;
                     mem_wdata.depth = cur_ff.req_depth;
                     mem_wdata.score = cur_ff.entry_score;
                     mem_wdata.move  = cur_ff.entry_move;
                  end
                  REQ_PROBE: begin
                     if (match_ff) begin
                        res.key_found  = 1'b1;
                        res.found_move = rd_slot_ff.move;
                        if (deep_ff) begin
                           hits_in         = hits_ff + COUNT_W'(1);
                           res.found_score = score_ff;
                           case (rd_slot_ff.bound)
                              BOUND_UPPER: begin
                                 if (score_ff <= cur_ff.window_alpha) begin
                                    res.found_score = cur_ff.window_alpha;
                                    res.cutoff      = 1'b1;
                                 end
                              end
                              BOUND_LOWER: begin
                                 if (score_ff >= cur_ff.window_beta) begin
                                    res.found_score = cur_ff.window_beta;
                                    res.cutoff      = 1'b1;
                                 end
                              end
                              BOUND_EXACT: res.cutoff = 1'b1;
                              default: ;
                           endcase
                        end
                     end
                  end
                  REQ_CLEAR: new_writes_in = '0;
                  default: ;
               endcase
               res.hit_count       = hits_in;
               res.new_write_count = new_writes_in;
               res.overwrite_count = overwrites_in;
               rsp_in              = res;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         init_ff       <= 1'b1;
         sweep_addr_ff <= '0;
         hits_ff       <= '0;
         new_writes_ff <= '0;
         overwrites_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_ff       <= init_in;
         sweep_addr_ff <= sweep_addr_in;
         hits_ff       <= hits_in;
         new_writes_ff <= new_writes_in;
         overwrites_ff <= overwrites_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      cur_index_ff <= cur_index_in;
      match_ff     <= match_in;
      empty_ff     <= empty_in;
      deep_ff      <= deep_in;
      score_ff     <= score_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (pop_fire) begin
         rd_slot_ff <= mem[pop_index];
      end
   end

`ifndef SYNTH
   a_no_result_during_init: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> !rsp_valid_ff)
      else $error("result item presented during the reset sweep");

   a_cutoff_needs_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.cutoff |-> rsp_ff.key_found)
      else $error("cutoff reported without a key match");

   a_write_only_on_store: assert property (@(posedge clock) disable iff (reset)
      mem_we && state_ff != ST_SWEEP |-> state_ff == ST_REPLY && cur_ff.req_type == REQ_STORE)
      else $error("slot written outside a store or sweep");

   a_pop_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      pop_fire |=> state_ff != ST_IDLE)
      else $error("item taken from the queue without being executed");
`endif

endmodule

>>> sv/transposition_table_probe_store.sv
// Top level of the direct-mapped transposition table with store, probe and clear.
module transposition_table_probe_store #(
   parameter int unsigned TABLE_ENTRIES = ttps_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // position_key, search_ply, req_depth, entry_move, entry_score, bound_kind,
   // window_alpha, window_beta, zero pad
   input  logic [ttps_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_type
   input  logic [ttps_pkg::KIND_W-1:0]        req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // found_move, found_score, hit_count, new_write_count, overwrite_count, zero pad
   output logic [ttps_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // key_found, cutoff
   output logic [ttps_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   input  logic                               csr_wr_en,
   input  logic [ttps_pkg::THR_W-1:0]         csr_wr_data
);
   // The table holds TABLE_ENTRIES slots of key and payload in a single-port
   // memory, indexed by the key modulo TABLE_ENTRIES. After reset a sweep
   // writes every slot to zero, and req_tready stays low until it ends. The
   // front part takes the slot index from the low key bits of the registered
   // item when TABLE_ENTRIES is a power of two, otherwise it reduces the key a
   // byte at a time, overlapped with the back part through a two-item queue.
   // The back part runs each store or probe as a memory read, a key check and
   // mate unshift, then a slot write and result, and takes no new item until
   // it is done. A clear item sweeps every slot to zero and then gives its result.
   // csr_wr_data sets the mate threshold, reset value 29936.
   import ttps_pkg::*;

   localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

   logic [THR_W-1:0] mate_threshold_ff, mate_threshold_in;
   req_item_type     req_item;
   req_item_type     push_item, pop_item;
   logic [IDX_W-1:0] push_index, pop_index;
   logic             push_valid, push_ready, pop_valid, pop_ready;
   logic             init_busy;
   result_type       rsp_item;

   assign mate_threshold_in = csr_wr_en ? csr_wr_data : mate_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mate_threshold_ff <= MATE_THRESHOLD_RESET;
      end else begin
         mate_threshold_ff <= mate_threshold_in;
      end
   end

   always_comb begin
      req_item.req_type     = req_tuser;
      req_item.position_key = req_tdata[63:0];
      req_item.search_ply   = req_tdata[69:64];
      req_item.req_depth    = req_tdata[75:70];
      req_item.entry_move   = req_tdata[100:76];
      req_item.entry_score  = req_tdata[116:101];
      req_item.bound_kind   = req_tdata[118:117];
      req_item.window_alpha = req_tdata[134:119];
      req_item.window_beta  = req_tdata[150:135];
   end

   ttps_front #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_item       (req_item),
      .mate_threshold (mate_threshold_ff),
      .init_busy      (init_busy),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_item      (push_item),
      .push_index     (push_index)
   );

   ttps_queue #(
      .IDX_W (IDX_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .push_index (push_index),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .pop_index  (pop_index)
   );

   ttps_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .mate_threshold (mate_threshold_ff),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_item       (pop_item),
      .pop_index      (pop_index),
      .init_busy      (init_busy),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_item       (rsp_item)
   );

   assign rsp_tdata = {7'b0, rsp_item.overwrite_count, rsp_item.new_write_count,
                       rsp_item.hit_count, rsp_item.found_score, rsp_item.found_move};
   assign rsp_tuser = {rsp_item.cutoff, rsp_item.key_found};

endmodule
